// ===== rtl/core/aabb_broad_phase_pairs_core_assert.svh =====
// assertion macros for the broad phase pair core
// used by the top level only, expects clk and rst in scope
`ifndef AABB_BROAD_PHASE_PAIRS_CORE_ASSERT_SVH
`define AABB_BROAD_PHASE_PAIRS_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define AABB_BP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("aabb_bp assertion failed");
`define AABB_BP_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("aabb_bp assertion failed");
`else
`define AABB_BP_ASSERT(label, prop)
`define AABB_BP_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ===== rtl/core/aabb_bp_pkg.sv =====
// shared types and constants for the broad phase pair core
// no dependencies
`default_nettype none

package aabb_bp_pkg;

  localparam int MAX_OBJECTS = 64;
  localparam int ID_W        = 6;
  localparam int COUNT_W     = 7;
  localparam int COORD_W     = 32;
  localparam int STEP_W      = $clog2(MAX_OBJECTS);

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_REPORT = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
    logic   dyn;
  } box_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/aabb_bp_cell.sv =====
// one ring cell: holds the box of one object slot
// depends on aabb_bp_pkg
`default_nettype none

module aabb_bp_cell (
  input  wire logic                    clk,
  input  wire aabb_bp_pkg::cell_ctrl_t ctrl,
  input  wire aabb_bp_pkg::box_t       load_box,
  input  wire aabb_bp_pkg::box_t       neighbor,
  output aabb_bp_pkg::box_t            box
);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      box <= load_box;
    end else if (ctrl.shift) begin
      box <= neighbor;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/aabb_bp_cmp.sv =====
// closed overlap test of two boxes on three axes, with the static pair filter
// depends on aabb_bp_pkg
`default_nettype none

module aabb_bp_cmp (
  input  wire aabb_bp_pkg::box_t a,
  input  wire aabb_bp_pkg::box_t b,
  output logic                   hit
);

  logic sep_x;
  logic sep_y;
  logic sep_z;

  always_comb begin
    sep_x = ($signed(a.max_x) < $signed(b.min_x)) || ($signed(b.max_x) < $signed(a.min_x));
    sep_y = ($signed(a.max_y) < $signed(b.min_y)) || ($signed(b.max_y) < $signed(a.min_y));
    sep_z = ($signed(a.max_z) < $signed(b.min_z)) || ($signed(b.max_z) < $signed(a.min_z));
    hit   = (a.dyn || b.dyn) && !sep_x && !sep_y && !sep_z;
  end

endmodule

`default_nettype wire

// ===== rtl/core/aabb_broad_phase_pairs_core.sv =====
// top level of the broad phase pair core: ring of box cells, sequencer, result register
// depends on aabb_bp_pkg, aabb_bp_cell, aabb_bp_cmp and the assertion header
`default_nettype none

// Boxes live in a ring of MAX_OBJECTS cells. A load transfer writes one cell
// directly. A report transfer rotates the whole ring once past a single
// comparator at cell 0: the reported object's box is captured as it passes,
// every later object below the count is tested against it, and hits leave in
// ascending order. A report holds the input for the whole rotation and the
// closing state, and longer while a hit or the closing result waits on a
// stalled output. The last result is marked; a report with no hit gives a
// single result with pair_found low. The output register lets a load or a
// new report transfer while the previous last result still waits.

`include "aabb_broad_phase_pairs_core_assert.svh"

module aabb_broad_phase_pairs_core (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_write,
  input  wire logic [aabb_bp_pkg::COUNT_W-1:0]       cfg_data,
  input  wire logic                                  item_valid,
  output logic                                       item_stall,
  input  wire logic                                  func,
  input  wire logic [aabb_bp_pkg::ID_W-1:0]          index,
  input  wire logic signed [aabb_bp_pkg::COORD_W-1:0] min_x,
  input  wire logic signed [aabb_bp_pkg::COORD_W-1:0] min_y,
  input  wire logic signed [aabb_bp_pkg::COORD_W-1:0] min_z,
  input  wire logic signed [aabb_bp_pkg::COORD_W-1:0] max_x,
  input  wire logic signed [aabb_bp_pkg::COORD_W-1:0] max_y,
  input  wire logic signed [aabb_bp_pkg::COORD_W-1:0] max_z,
  input  wire logic                                  active,
  output logic                                       result_valid,
  input  wire logic                                  result_stall,
  output logic                                       pair_found,
  output logic [aabb_bp_pkg::ID_W-1:0]               first_id,
  output logic [aabb_bp_pkg::ID_W-1:0]               second_id,
  output logic                                       last
);

  aabb_bp_pkg::state_t state;
  aabb_bp_pkg::state_t state_next;

  logic [aabb_bp_pkg::STEP_W-1:0]  step;
  logic [aabb_bp_pkg::COUNT_W-1:0] count;
  logic [aabb_bp_pkg::ID_W-1:0]    idx;
  aabb_bp_pkg::box_t               query;
  logic                            pend_valid;
  logic [aabb_bp_pkg::ID_W-1:0]    pend_id;

  aabb_bp_pkg::box_t boxes [aabb_bp_pkg::MAX_OBJECTS];
  aabb_bp_pkg::box_t load_box;

  logic load_fire;
  logic report_fire;
  logic out_free;
  logic cmp_hit;
  logic hit;
  logic advance;
  logic push;
  logic finish_fire;
  logic last_step;
  logic walking;

  assign load_box = '{min_x: min_x, min_y: min_y, min_z: min_z,
                      max_x: max_x, max_y: max_y, max_z: max_z, dyn: active};

  // ring of cells, cell k takes from cell k+1
  for (genvar k = 0; k < aabb_bp_pkg::MAX_OBJECTS; k++) begin : g_cell
    aabb_bp_pkg::cell_ctrl_t ctrl;
    assign ctrl.load  = load_fire && (index == aabb_bp_pkg::ID_W'(k));
    assign ctrl.shift = advance;
    aabb_bp_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .load_box (load_box),
      .neighbor (boxes[(k + 1) % aabb_bp_pkg::MAX_OBJECTS]),
      .box      (boxes[k])
    );
  end

  aabb_bp_cmp u_cmp (
    .a   (query),
    .b   (boxes[0]),
    .hit (cmp_hit)
  );

  always_comb begin
    out_free    = !result_valid || !result_stall;
    walking     = (state == aabb_bp_pkg::ST_WALK);
    hit         = walking && cmp_hit
                  && (aabb_bp_pkg::ID_W'(step) > idx)
                  && (aabb_bp_pkg::COUNT_W'(step) < count);
    advance     = walking && !(hit && pend_valid && !out_free);
    push        = walking && hit && pend_valid && out_free;
    finish_fire = (state == aabb_bp_pkg::ST_FINISH) && out_free;
    last_step   = (step == aabb_bp_pkg::STEP_W'(aabb_bp_pkg::MAX_OBJECTS - 1));
    load_fire   = item_valid && !item_stall && (func == aabb_bp_pkg::FUNC_LOAD);
    report_fire = item_valid && !item_stall && (func == aabb_bp_pkg::FUNC_REPORT);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      aabb_bp_pkg::ST_IDLE: begin
        if (report_fire) begin
          state_next = aabb_bp_pkg::ST_WALK;
        end
      end
      aabb_bp_pkg::ST_WALK: begin
        if (advance && last_step) begin
          state_next = aabb_bp_pkg::ST_FINISH;
        end
      end
      aabb_bp_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = aabb_bp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = aabb_bp_pkg::ST_IDLE;
      end
    endcase
  end

  // fsm outputs
  always_comb begin
    case (state)
      aabb_bp_pkg::ST_IDLE: item_stall = 1'b0;
      default:              item_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= aabb_bp_pkg::ST_IDLE;
      step         <= '0;
      count        <= '0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        count <= (cfg_data > aabb_bp_pkg::COUNT_W'(aabb_bp_pkg::MAX_OBJECTS))
                 ? aabb_bp_pkg::COUNT_W'(aabb_bp_pkg::MAX_OBJECTS) : cfg_data;
      end
      if (advance) begin
        step <= last_step ? '0 : step + 1'b1;
      end
      if (finish_fire) begin
        pend_valid <= 1'b0;
      end else if (hit && advance) begin
        pend_valid <= 1'b1;
      end
      if (push || finish_fire) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (report_fire) begin
      idx <= index;
    end
    if (advance && (aabb_bp_pkg::ID_W'(step) == idx)) begin
      query <= boxes[0];
    end
    if (hit && advance) begin
      pend_id <= aabb_bp_pkg::ID_W'(step);
    end
    if (push) begin
      pair_found <= 1'b1;
      first_id   <= idx;
      second_id  <= pend_id;
      last       <= 1'b0;
    end else if (finish_fire) begin
      pair_found <= pend_valid;
      first_id   <= idx;
      second_id  <= pend_valid ? pend_id : '0;
      last       <= 1'b1;
    end
  end

  // ring must be back in place whenever loads can be taken
  `AABB_BP_ASSERT(a_ring_aligned_idle, (state == aabb_bp_pkg::ST_IDLE) |-> (step == '0))
  `AABB_BP_ASSERT(a_no_pending_idle, (state == aabb_bp_pkg::ST_IDLE) |-> !pend_valid)
  `AABB_BP_ASSERT(a_finish_gives_last, finish_fire |=> (result_valid && last))
  `AABB_BP_ASSERT_ALWAYS(a_empty_is_last, (result_valid && !pair_found) |-> last)

endmodule

`default_nettype wire

// ===== sim/aabb_broad_phase_pairs_core_tb.sv =====
// self-checking testbench for aabb_broad_phase_pairs_core: loads boxes, requests pair
// reports and checks every result transfer against an in-bench overlap predictor
// depends on aabb_bp_pkg and the aabb_broad_phase_pairs_core rtl
`timescale 1ns / 100ps

module aabb_broad_phase_pairs_core_tb;

  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = aabb_bp_pkg::MAX_OBJECTS + 8;
  localparam int LIMIT_CYCLES = 400000;
  localparam int PHASE_ITEMS  = 10;
  localparam logic signed [aabb_bp_pkg::COORD_W-1:0] UNIT = 32'sh0001_0000;

  typedef struct packed {
    logic                         pair_found;
    logic [aabb_bp_pkg::ID_W-1:0] first_id;
    logic [aabb_bp_pkg::ID_W-1:0] second_id;
    logic                         last;
  } pair_result_t;

  logic                                   clk;
  logic                                   rst;
  logic                                   cfg_write;
  logic [aabb_bp_pkg::COUNT_W-1:0]        cfg_data;
  logic                                   item_valid;
  logic                                   item_stall;
  logic                                   func;
  logic [aabb_bp_pkg::ID_W-1:0]           index;
  logic signed [aabb_bp_pkg::COORD_W-1:0] min_x, min_y, min_z, max_x, max_y, max_z;
  logic                                   active;
  logic                                   result_valid;
  logic                                   result_stall;
  logic                                   pair_found;
  logic [aabb_bp_pkg::ID_W-1:0]           first_id;
  logic [aabb_bp_pkg::ID_W-1:0]           second_id;
  logic                                   last;

  aabb_bp_pkg::box_t box_store [aabb_bp_pkg::MAX_OBJECTS];
  int                object_limit;
  pair_result_t      pending_pairs [$];
  int                error_count;
  int                reports_seen;
  int                pairs_seen;
  int                empty_seen;
  int                counts_written;
  bit                steady;
  bit                hold_request;

  aabb_broad_phase_pairs_core DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .func         (func),
    .index        (index),
    .min_x        (min_x),
    .min_y        (min_y),
    .min_z        (min_z),
    .max_x        (max_x),
    .max_y        (max_y),
    .max_z        (max_z),
    .active       (active),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .pair_found   (pair_found),
    .first_id     (first_id),
    .second_id    (second_id),
    .last         (last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("FAIL aabb_broad_phase_pairs_core");
    $finish;
  end

  function automatic logic box_overlap(aabb_bp_pkg::box_t a, aabb_bp_pkg::box_t b);
    logic ox, oy, oz;
    ox = !($signed(a.max_x) < $signed(b.min_x) || $signed(b.max_x) < $signed(a.min_x));
    oy = !($signed(a.max_y) < $signed(b.min_y) || $signed(b.max_y) < $signed(a.min_y));
    oz = !($signed(a.max_z) < $signed(b.min_z) || $signed(b.max_z) < $signed(a.min_z));
    return ox && oy && oz;
  endfunction

  // stores the box of a load transfer, or works out the pair list of a report transfer, from the signals at the edge
  task automatic predict_pairs();
    aabb_bp_pkg::box_t b;
    pair_result_t      r;
    int                hits;
    hits = 0;
    if (func == aabb_bp_pkg::FUNC_LOAD) begin
      b.min_x = min_x;
      b.min_y = min_y;
      b.min_z = min_z;
      b.max_x = max_x;
      b.max_y = max_y;
      b.max_z = max_z;
      b.dyn   = active;
      box_store[index] = b;
    end else begin
      reports_seen++;
      if (int'(index) < object_limit) begin
        for (int j = int'(index) + 1; j < object_limit; j++) begin
          if ((box_store[index].dyn || box_store[j].dyn) &&
              box_overlap(box_store[index], box_store[j])) begin
            r.pair_found = 1'b1;
            r.first_id   = index;
            r.second_id  = j[aabb_bp_pkg::ID_W-1:0];
            r.last       = 1'b0;
            pending_pairs = {pending_pairs, r};
            hits++;
          end
        end
      end
      if (hits == 0) begin
        r.pair_found = 1'b0;
        r.first_id   = index;
        r.second_id  = '0;
        r.last       = 1'b1;
        pending_pairs = {pending_pairs, r};
      end else begin
        pending_pairs[pending_pairs.size() - 1].last = 1'b1;
      end
    end
  endtask

  // input transfers are predicted before result transfers of the same edge are checked
  always @(posedge clk) begin
    pair_result_t want;
    if (!rst) begin
      if (cfg_write)
        object_limit = (int'(cfg_data) > aabb_bp_pkg::MAX_OBJECTS) ?
                       aabb_bp_pkg::MAX_OBJECTS : int'(cfg_data);
      if (item_valid && !item_stall)
        predict_pairs();
      if (result_valid && !result_stall) begin
        if (pending_pairs.size() == 0) begin
          $display("%0t unexpected result: pair_found %0b first_id %0d second_id %0d last %0b",
                   $time, pair_found, first_id, second_id, last);
          error_count++;
        end else begin
          want = pending_pairs.pop_front();
          if (pair_found !== want.pair_found) begin
            $display("%0t pair_found expected %0b actual %0b", $time, want.pair_found,
                     pair_found);
            error_count++;
          end
          if (first_id !== want.first_id) begin
            $display("%0t first_id expected %0d actual %0d", $time, want.first_id, first_id);
            error_count++;
          end
          if (second_id !== want.second_id) begin
            $display("%0t second_id expected %0d actual %0d", $time, want.second_id,
                     second_id);
            error_count++;
          end
          if (last !== want.last) begin
            $display("%0t last expected %0b actual %0b", $time, want.last, last);
            error_count++;
          end
          if (want.pair_found)
            pairs_seen++;
          else
            empty_seen++;
        end
      end
    end
  end

  // result side: random stalls, steady stretches and one long hold-off on request
  initial begin : result_side
    int held;
    bit hold_taken;
    held = 0;
    hold_taken = 1'b0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_taken) begin
        held = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (held > 0) begin
        result_stall <= 1'b1;
        held--;
      end else if (steady || rst) begin
        result_stall <= 1'b0;
      end else begin
        result_stall <= ($urandom_range(99) < 8);
      end
    end
  end

  // mostly grid-aligned bounds so that touching and nested boxes are common, with some random and some inverted boxes
  function automatic aabb_bp_pkg::box_t rand_box();
    aabb_bp_pkg::box_t                      b;
    int unsigned                            mode;
    logic signed [aabb_bp_pkg::COORD_W-1:0] lo [3];
    logic signed [aabb_bp_pkg::COORD_W-1:0] hi [3];
    logic signed [aabb_bp_pkg::COORD_W-1:0] t;
    mode = $urandom_range(99);
    for (int k = 0; k < 3; k++) begin
      if (mode < 15) begin
        lo[k] = $urandom;
        hi[k] = $urandom;
      end else begin
        lo[k] = (int'($urandom_range(16)) - 8) * UNIT;
        hi[k] = lo[k] + int'($urandom_range(6)) * UNIT;
        if (mode < 25) begin
          t = lo[k];
          lo[k] = hi[k];
          hi[k] = t;
        end
      end
    end
    b.min_x = lo[0];
    b.min_y = lo[1];
    b.min_z = lo[2];
    b.max_x = hi[0];
    b.max_y = hi[1];
    b.max_z = hi[2];
    b.dyn   = ($urandom_range(99) < 60);
    return b;
  endfunction

  // entered and left just after a falling edge; valid stays high into the next call
  task automatic send_item(input logic f, input logic [aabb_bp_pkg::ID_W-1:0] idx,
                           input aabb_bp_pkg::box_t b);
    if (!steady) begin
      while ($urandom_range(99) < 8) begin
        item_valid <= 1'b0;
        @(negedge clk);
      end
    end
    item_valid <= 1'b1;
    func       <= f;
    index      <= idx;
    min_x      <= b.min_x;
    min_y      <= b.min_y;
    min_z      <= b.min_z;
    max_x      <= b.max_x;
    max_y      <= b.max_y;
    max_z      <= b.max_z;
    active     <= b.dyn;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
  endtask

  task automatic wait_pairs_done();
    item_valid <= 1'b0;
    while (pending_pairs.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_object_count(input logic [aabb_bp_pkg::COUNT_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
    counts_written++;
  endtask

  task automatic send_random_item();
    logic [aabb_bp_pkg::ID_W-1:0] idx;
    if ($urandom_range(99) < 35) begin
      send_item(aabb_bp_pkg::FUNC_LOAD,
                aabb_bp_pkg::ID_W'($urandom_range(aabb_bp_pkg::MAX_OBJECTS - 1)), rand_box());
    end else begin
      if (object_limit > 0 && $urandom_range(99) < 85)
        idx = aabb_bp_pkg::ID_W'($urandom_range(object_limit - 1));
      else
        idx = aabb_bp_pkg::ID_W'($urandom_range(aabb_bp_pkg::MAX_OBJECTS - 1));
      send_item(aabb_bp_pkg::FUNC_REPORT, idx, rand_box());
    end
  endtask

  task automatic test_empty_count();
    set_object_count(7'd0);
    send_item(aabb_bp_pkg::FUNC_REPORT, 6'd0, rand_box());
    send_item(aabb_bp_pkg::FUNC_REPORT,
              aabb_bp_pkg::ID_W'(aabb_bp_pkg::MAX_OBJECTS - 1), rand_box());
    wait_pairs_done();
  endtask

  // touching bounds, both-static pair, inverted box and full-range bounds
  task automatic test_directed_boxes();
    aabb_bp_pkg::box_t b;
    set_object_count(7'd4);
    b = '{min_x: 0, min_y: 0, min_z: 0, max_x: 2 * UNIT, max_y: 2 * UNIT,
          max_z: 2 * UNIT, dyn: 1'b1};
    send_item(aabb_bp_pkg::FUNC_LOAD, 6'd0, b);
    b = '{min_x: 2 * UNIT, min_y: 0, min_z: 0, max_x: 4 * UNIT, max_y: 2 * UNIT,
          max_z: 2 * UNIT, dyn: 1'b0};
    send_item(aabb_bp_pkg::FUNC_LOAD, 6'd1, b);
    b = '{min_x: UNIT, min_y: UNIT, min_z: -UNIT, max_x: 3 * UNIT, max_y: UNIT,
          max_z: 0, dyn: 1'b0};
    send_item(aabb_bp_pkg::FUNC_LOAD, 6'd2, b);
    b = '{min_x: 3 * UNIT, min_y: 32'sh8000_0000, min_z: 32'sh8000_0000, max_x: UNIT,
          max_y: 32'sh7fff_ffff, max_z: 32'sh7fff_ffff, dyn: 1'b1};
    send_item(aabb_bp_pkg::FUNC_LOAD, 6'd3, b);
    for (int k = 0; k < 5; k++)
      send_item(aabb_bp_pkg::FUNC_REPORT, aabb_bp_pkg::ID_W'(k), rand_box());
    send_item(aabb_bp_pkg::FUNC_REPORT,
              aabb_bp_pkg::ID_W'(aabb_bp_pkg::MAX_OBJECTS - 1), rand_box());
    wait_pairs_done();
    b = '{min_x: 32'sh8000_0000, min_y: 32'sh8000_0000, min_z: 32'sh8000_0000,
          max_x: 32'sh7fff_ffff, max_y: 32'sh7fff_ffff, max_z: 32'sh7fff_ffff,
          dyn: 1'b0};
    send_item(aabb_bp_pkg::FUNC_LOAD, 6'd2, b);
    b = '{min_x: 32'sh7fff_ffff, min_y: 32'sh7fff_ffff, min_z: 32'sh7fff_ffff,
          max_x: 32'sh8000_0000, max_y: 32'sh8000_0000, max_z: 32'sh8000_0000,
          dyn: 1'b1};
    send_item(aabb_bp_pkg::FUNC_LOAD, 6'd1, b);
    for (int k = 0; k < 4; k++)
      send_item(aabb_bp_pkg::FUNC_REPORT, aabb_bp_pkg::ID_W'(k), rand_box());
    wait_pairs_done();
  endtask

  task automatic test_fill_store();
    for (int k = 0; k < aabb_bp_pkg::MAX_OBJECTS; k++)
      send_item(aabb_bp_pkg::FUNC_LOAD, aabb_bp_pkg::ID_W'(k), rand_box());
    wait_pairs_done();
  endtask

  task automatic test_count_settings();
    logic [aabb_bp_pkg::COUNT_W-1:0] counts [8];
    counts = '{7'd64, 7'd127, 7'd1, 7'd2, 7'd0, 7'd65, 7'd3, 7'd3};
    counts[6] = aabb_bp_pkg::COUNT_W'($urandom_range(aabb_bp_pkg::MAX_OBJECTS - 1, 3));
    counts[7] = aabb_bp_pkg::COUNT_W'($urandom_range(aabb_bp_pkg::MAX_OBJECTS - 1, 3));
    foreach (counts[p]) begin
      set_object_count(counts[p]);
      steady = (p == 6);
      repeat (PHASE_ITEMS) send_random_item();
      wait_pairs_done();
    end
    steady = 1'b0;
  endtask

  // receiver holds off while the sender keeps offering, so the core backs up
  task automatic test_output_holdoff();
    set_object_count(aabb_bp_pkg::COUNT_W'(aabb_bp_pkg::MAX_OBJECTS));
    hold_request = 1'b1;
    for (int k = 0; k < 16; k++) begin
      if (k % 4 == 3)
        send_item(aabb_bp_pkg::FUNC_LOAD,
                  aabb_bp_pkg::ID_W'($urandom_range(aabb_bp_pkg::MAX_OBJECTS - 1)),
                  rand_box());
      else
        send_item(aabb_bp_pkg::FUNC_REPORT, aabb_bp_pkg::ID_W'($urandom_range(15)),
                  rand_box());
    end
    wait_pairs_done();
  endtask

  task automatic test_sender_pause();
    set_object_count(aabb_bp_pkg::COUNT_W'($urandom_range(aabb_bp_pkg::MAX_OBJECTS, 8)));
    repeat (10) send_random_item();
    item_valid <= 1'b0;
    while (pending_pairs.size() != 0) @(negedge clk);
    @(negedge clk);
    repeat (10) send_random_item();
    wait_pairs_done();
  endtask

  initial begin
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_data     = '0;
    item_valid   = 1'b0;
    func         = aabb_bp_pkg::FUNC_LOAD;
    index        = '0;
    min_x        = '0;
    min_y        = '0;
    min_z        = '0;
    max_x        = '0;
    max_y        = '0;
    max_z        = '0;
    active       = 1'b0;
    object_limit = 0;
    error_count  = 0;
    reports_seen = 0;
    pairs_seen   = 0;
    empty_seen   = 0;
    counts_written = 0;
    steady       = 1'b0;
    hold_request = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_count();
    test_directed_boxes();
    test_fill_store();
    test_count_settings();
    test_output_holdoff();
    test_sender_pause();

    if (pending_pairs.size() != 0) begin
      $display("%0t %0d expected results never arrived", $time, pending_pairs.size());
      error_count++;
    end
    $display("covered %0d reports over %0d object counts: %0d pairs and %0d empty reports",
             reports_seen, counts_written, pairs_seen, empty_seen);
    $display("with random stalls on both sides, a %0d cycle result hold-off and a sender pause",
             HOLD_CYCLES);
    if (error_count == 0)
      $display("PASS aabb_broad_phase_pairs_core");
    else
      $display("FAIL aabb_broad_phase_pairs_core");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/aabb_bp_pkg.sv
rtl/core/aabb_bp_cell.sv
rtl/core/aabb_bp_cmp.sv
rtl/core/aabb_broad_phase_pairs_core.sv
sim/aabb_broad_phase_pairs_core_tb.sv
